FILE: hdl/msp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool package
// Default sizes and the operation and status codes of the shared pool stacks.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int NUM_STACKS_DEF = 4;
    localparam int POOL_SLOTS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

endpackage

FILE: hdl/multi_stack_shared_pool_core.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool core
// Several LIFO stacks that share one slot store, with a free list threaded
// through the link field of every slot.
// ----------------------------------------------------------------------------
// Each item passes through three states from acceptance to result: the accept
// cycle in S_IDLE reads the top pointer memory, S_SLOT reads the slot memory at
// the free list head or the stack top, and S_COMMIT writes both memories back
// and loads the result register once any waiting result is taken. A new
// item is accepted in the cycle after that, so the core does not take a new
// item before it is through with the last one, because of the two dependent
// reads of the synchronous memories. A waiting result does not block the next
// item from being taken. No clearing pass is needed after reset.
module multi_stack_shared_pool_core #(
    parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
    parameter int POOL_SLOTS = msp_pkg::POOL_SLOTS_DEF,
    parameter int VALUE_BITS = msp_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [1:0]         stack_id,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status,
    output logic               pool_full,
    output logic               stack_empty
);

    localparam int SLOT_BITS = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int PTR_BITS  = $clog2(POOL_SLOTS + 1);
    localparam int ID_BITS   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int ENTRY_BITS = PTR_BITS + VALUE_BITS;
    localparam logic [PTR_BITS-1:0] NULL_PTR = PTR_BITS'(POOL_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_COMMIT
    } state_t;

    state_t state_reg;

    logic [ENTRY_BITS-1:0] slot_mem [POOL_SLOTS];
    logic [PTR_BITS-1:0]   top_mem  [NUM_STACKS];

    logic [POOL_SLOTS-1:0] link_valid_reg;
    logic [NUM_STACKS-1:0] top_valid_reg;
    logic [PTR_BITS-1:0]   free_head_reg;

    logic                  kind_reg;
    logic                  valid_id_reg;
    logic [ID_BITS-1:0]    sid_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic [PTR_BITS-1:0]   top_rd_reg;
    logic                  top_vld_reg;
    logic [ENTRY_BITS-1:0] slot_rd_reg;
    logic                  slot_vld_reg;
    logic [SLOT_BITS-1:0]  slot_addr_reg;

    logic                  out_valid_reg;
    logic signed [31:0]    pop_value_reg;
    logic [1:0]            status_reg;
    logic                  pool_full_reg;
    logic                  stack_empty_reg;

    logic                  accept;
    logic                  commit;
    logic                  valid_id;
    logic [ID_BITS-1:0]    id_idx;
    logic [PTR_BITS-1:0]   top_cur;
    logic                  top_null;
    logic                  free_null;
    logic [SLOT_BITS-1:0]  slot_addr;
    logic [PTR_BITS-1:0]   slot_link;
    logic                  link_null;
    logic [VALUE_BITS-1:0] slot_value;
    logic                  push_ok;
    logic                  pop_ok;

    assign accept    = in_valid && !in_stall;
    assign commit    = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign valid_id  = ({30'd0, stack_id} < 32'(NUM_STACKS));
    assign id_idx    = ID_BITS'(stack_id);

    assign top_cur   = top_vld_reg ? top_rd_reg : NULL_PTR;
    assign top_null  = (top_cur >= NULL_PTR);
    assign free_null = (free_head_reg >= NULL_PTR);
    assign slot_addr = (kind_reg == msp_pkg::KIND_PUSH) ? free_head_reg[SLOT_BITS-1:0]
                                                         : top_cur[SLOT_BITS-1:0];

    assign slot_link  = slot_vld_reg ? slot_rd_reg[ENTRY_BITS-1:VALUE_BITS]
                                     : PTR_BITS'(slot_addr_reg) + PTR_BITS'(1);
    assign link_null  = (slot_link >= NULL_PTR);
    assign slot_value = slot_rd_reg[VALUE_BITS-1:0];

    assign push_ok = (kind_reg == msp_pkg::KIND_PUSH) && valid_id_reg && !free_null;
    assign pop_ok  = (kind_reg == msp_pkg::KIND_POP) && valid_id_reg && !top_null;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= top_mem[id_idx];
        end
        if (state_reg == S_SLOT)
        begin
            slot_rd_reg <= slot_mem[slot_addr];
        end
        if (commit && push_ok)
        begin
            slot_mem[slot_addr_reg] <= {top_cur, value_reg};
            top_mem[sid_reg]        <= PTR_BITS'(slot_addr_reg);
        end
        else if (commit && pop_ok)
        begin
            slot_mem[slot_addr_reg] <= {free_head_reg, slot_value};
            top_mem[sid_reg]        <= slot_link;
        end
        if (accept)
        begin
            kind_reg  <= kind;
            sid_reg   <= id_idx;
            value_reg <= VALUE_BITS'($unsigned(push_value));
        end
        if (state_reg == S_SLOT)
        begin
            slot_addr_reg <= slot_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            link_valid_reg  <= '0;
            top_valid_reg   <= '0;
            free_head_reg   <= '0;
            valid_id_reg    <= 1'b0;
            top_vld_reg     <= 1'b0;
            slot_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pop_value_reg   <= '0;
            status_reg      <= msp_pkg::ST_OK;
            pool_full_reg   <= 1'b0;
            stack_empty_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        valid_id_reg <= valid_id;
                        top_vld_reg  <= valid_id && top_valid_reg[id_idx];
                        state_reg    <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    slot_vld_reg <= link_valid_reg[slot_addr];
                    state_reg    <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (commit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (push_ok)
                        begin
                            link_valid_reg[slot_addr_reg] <= 1'b1;
                            top_valid_reg[sid_reg]        <= 1'b1;
                            free_head_reg                 <= slot_link;
                            pop_value_reg                 <= '0;
                            status_reg                    <= msp_pkg::ST_OK;
                            pool_full_reg                 <= link_null;
                            stack_empty_reg               <= 1'b0;
                        end
                        else if (pop_ok)
                        begin
                            link_valid_reg[slot_addr_reg] <= 1'b1;
                            free_head_reg                 <= top_cur;
                            pop_value_reg                 <= 32'($signed(slot_value));
                            status_reg                    <= msp_pkg::ST_OK;
                            pool_full_reg                 <= 1'b0;
                            stack_empty_reg               <= link_null;
                        end
                        else
                        begin
                            pop_value_reg   <= '0;
                            status_reg      <= (kind_reg == msp_pkg::KIND_PUSH)
                                               ? msp_pkg::ST_OVERFLOW
                                               : msp_pkg::ST_UNDERFLOW;
                            pool_full_reg   <= free_null;
                            stack_empty_reg <= valid_id_reg ? top_null : 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pop_value   = pop_value_reg;
    assign status      = status_reg;
    assign pool_full   = pool_full_reg;
    assign stack_empty = stack_empty_reg;

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SLOT))
        else $error("accepted item did not start the slot read");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("commit did not load a result");

    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NULL_PTR)
        else $error("free list head outside the pool");

    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == msp_pkg::ST_UNDERFLOW)) |-> (pop_value_reg == 0))
        else $error("failed pop returned a value");

    a_ok_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == msp_pkg::ST_OK)) |-> !(pool_full_reg && stack_empty_reg))
        else $error("successful operation left a full pool and an empty stack");

endmodule

FILE: dv/pool_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shared pool stack checker
// Watches both item channels of the shared pool stack core. It keeps its own
// copy of the free list, the stack tops and the slot contents, and predicts
// the result of every accepted operation. It then compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pool_stack_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [1:0]  stack_id,
    input  logic [31:0] push_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] pop_value,
    input  logic [1:0]  status,
    input  logic        pool_full,
    input  logic        stack_empty,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          overflows_seen,
    output int          underflows_seen
);

    localparam int SLOTS     = msp_pkg::POOL_SLOTS_DEF;
    localparam int STACKS    = msp_pkg::NUM_STACKS_DEF;
    localparam int LINK_W    = $clog2(SLOTS + 1);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int NULL_LINK = SLOTS;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
        logic        full;
        logic        empty;
    } pool_result_t;

    logic [31:0]       slot_value [SLOTS];
    logic [LINK_W-1:0] slot_link [SLOTS];
    logic [LINK_W-1:0] stack_top [STACKS];
    logic [LINK_W-1:0] free_head;

    pool_result_t result_q[$];
    int errors    = 0;
    int checked   = 0;
    int overflow  = 0;
    int underflow = 0;

    function automatic pool_result_t predict_pool_op(input logic op, input logic [1:0] sid,
                                                     input logic [31:0] value);
        pool_result_t r;
        logic [SLOT_W-1:0] slot;
        r = '0;
        r.status = msp_pkg::ST_OK;
        if (op == msp_pkg::KIND_PUSH)
        begin
            if (free_head >= NULL_LINK)
            begin
                r.status = msp_pkg::ST_OVERFLOW;
            end
            else
            begin
                slot = SLOT_W'(free_head);
                free_head = slot_link[slot];
                slot_link[slot] = stack_top[sid];
                stack_top[sid] = LINK_W'(slot);
                slot_value[slot] = value;
            end
        end
        else
        begin
            if (stack_top[sid] >= NULL_LINK)
            begin
                r.status = msp_pkg::ST_UNDERFLOW;
            end
            else
            begin
                slot = SLOT_W'(stack_top[sid]);
                r.pop_value = slot_value[slot];
                stack_top[sid] = slot_link[slot];
                slot_link[slot] = free_head;
                free_head = LINK_W'(slot);
            end
        end
        r.empty = (stack_top[sid] >= NULL_LINK);
        r.full  = (free_head >= NULL_LINK);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_value[i] = '0;
                slot_link[i]  = LINK_W'(i + 1);
            end
            for (int s = 0; s < STACKS; s++)
            begin
                stack_top[s] = LINK_W'(NULL_LINK);
            end
            free_head = '0;
            result_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no item outstanding: pop_value %0h status %0d",
                           pop_value, status);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("pop_value", want.pop_value, pop_value);
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("pool_full", 32'(want.full), 32'(pool_full));
                    check_field("stack_empty", 32'(want.empty), 32'(stack_empty));
                    checked++;
                    if (want.status == msp_pkg::ST_OVERFLOW)
                    begin
                        overflow++;
                    end
                    if (want.status == msp_pkg::ST_UNDERFLOW)
                    begin
                        underflow++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                result_q.push_back(predict_pool_op(kind, stack_id, push_value));
            end
        end
        fail_count      <= errors;
        pending         <= result_q.size();
        results_checked <= checked;
        overflows_seen  <= overflow;
        underflows_seen <= underflow;
    end

endmodule

FILE: dv/tb_multi_stack_shared_pool_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shared pool stack core testbench
// Drives push and pop items into the core: a directed opening that pops an
// empty stack, fills the pool, overflows it and empties one stack, followed
// by random operation mixes under three idle patterns. A long output hold
// and full drains between phases put pressure on the handshakes. The checker
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_pool_core;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        kind       = msp_pkg::KIND_PUSH;
    logic [1:0]  stack_id   = 2'd0;
    logic [31:0] push_value = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] pop_value;
    logic [1:0]  status;
    logic        pool_full;
    logic        stack_empty;

    int fail_count;
    int pending;
    int results_checked;
    int overflows_seen;
    int underflows_seen;

    int send_idle_pct = 30;
    int recv_idle_pct = 48;
    int hold_left     = 0;
    int ops_sent      = 0;
    int quiet_cycles  = 0;

    always #1 clk = ~clk;

    multi_stack_shared_pool_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .stack_id    (stack_id),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pop_value   (pop_value),
        .status      (status),
        .pool_full   (pool_full),
        .stack_empty (stack_empty)
    );

    pool_stack_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .stack_id        (stack_id),
        .push_value      (push_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pop_value       (pop_value),
        .status          (status),
        .pool_full       (pool_full),
        .stack_empty     (stack_empty),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .overflows_seen  (overflows_seen),
        .underflows_seen (underflows_seen)
    );

    task automatic offer_op(input logic op, input logic [1:0] sid, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        stack_id   <= sid;
        push_value <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ops_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic run_random_ops(input int count);
        int push_pct;
        logic op;
        logic [31:0] value;
        push_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            op = ($urandom_range(99) < push_pct) ? msp_pkg::KIND_PUSH : msp_pkg::KIND_POP;
            case ($urandom_range(7))
                0: value = 32'h7fff_ffff;
                1: value = 32'h8000_0000;
                2: value = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
                default: value = $urandom;
            endcase
            offer_op(op, 2'($urandom_range(3)), value);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_multi_stack_shared_pool_core NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0] edge_values [8];
        int send_mix [3];
        int recv_mix [3];
        edge_values = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                        32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'hfffffffe};
        send_mix = '{30, 48, 0};
        recv_mix = '{48, 30, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_op(msp_pkg::KIND_POP, 2'd3, 32'hdead_beef);
        for (int i = 0; i < 16; i++)
        begin
            offer_op(msp_pkg::KIND_PUSH, (i < 8) ? 2'(i % 4) : 2'd2,
                     (i < 8) ? edge_values[i] : $urandom);
        end
        offer_op(msp_pkg::KIND_PUSH, 2'd1, 32'h1234_5678);
        for (int s = 0; s < 4; s++)
        begin
            offer_op(msp_pkg::KIND_POP, 2'(s), 32'hffff_ffff);
        end
        offer_op(msp_pkg::KIND_POP, 2'd3, 32'h0);
        offer_op(msp_pkg::KIND_PUSH, 2'd3, 32'h8000_0001);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = send_mix[ph];
            recv_idle_pct = recv_mix[ph];
            run_random_ops(10);
            if (ph < 2)
            begin
                hold_left = 120;
            end
            run_random_ops(350);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d push and pop items under three idle mixes, with a long output hold",
                 ops_sent);
        $display("and full drains; checked %0d results, %0d overflows, %0d underflows.",
                 results_checked, overflows_seen, underflows_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_multi_stack_shared_pool_core OK");
        end
        else
        begin
            $display("tb_multi_stack_shared_pool_core NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/msp_pkg.sv
hdl/multi_stack_shared_pool_core.sv
dv/pool_stack_checker.sv
dv/tb_multi_stack_shared_pool_core.sv
